// File: src/hfmt_pkg.sv
// hfmt_pkg: shared types and constants for the hash frequency mode tracker.
// No dependencies; imported by every module of the block.
package hfmt_pkg;

  localparam int unsigned ENTRIES_DEF   = 64;
  localparam int unsigned HASH_BITS_DEF = 32;

  localparam int unsigned CNT_W   = 32;
  localparam int unsigned PCT_W   = 15;
  localparam int unsigned OUT_W   = 32;
  // 100 percent in Q7.8
  localparam logic [PCT_W-1:0] PCT_SCALE = PCT_W'(100 * 256);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_DONE
  } state_e;

  // control flags that travel with a probe beat along the cell chain
  typedef struct packed {
    logic vld;   // probe present
    logic hit;   // hash already found in an earlier cell
    logic app;   // hash appended into a free cell
    logic inc;   // total adds must be raised
  } probe_t;

endpackage

// File: src/hfmt_cell.sv
// hfmt_cell: one table slot (hash and count) plus one stage of the probe chain.
// Depends on hfmt_pkg.
module hfmt_cell import hfmt_pkg::*; #(
  parameter int unsigned HASH_BITS = HASH_BITS_DEF,
  parameter int unsigned UW        = 7,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [UW-1:0]        used_i,
  input  probe_t               probe_i,
  input  logic [HASH_BITS-1:0] key_i,
  input  logic [CNT_W-1:0]     bcnt_i,
  input  logic [HASH_BITS-1:0] bhash_i,
  output probe_t               probe_o,
  output logic [HASH_BITS-1:0] key_o,
  output logic [CNT_W-1:0]     bcnt_o,
  output logic [HASH_BITS-1:0] bhash_o
);

  logic [HASH_BITS-1:0] hash_q;
  logic [CNT_W-1:0]     cnt_q;

  logic                 occupied, fresh, match, append, sat;
  logic [CNT_W-1:0]     cur_cnt;
  probe_t               probe_d, probe_q;
  logic [CNT_W-1:0]     bcnt_d, bcnt_q;
  logic [HASH_BITS-1:0] bhash_d, bhash_q, key_q;

  always_comb begin
    occupied = UW'(IDX) < used_i;
    fresh    = UW'(IDX) == used_i;
    match    = probe_i.vld && occupied && !probe_i.hit && (hash_q == key_i);
    append   = probe_i.vld && fresh && !probe_i.hit;
    sat      = cnt_q == CNT_MAX;
    cur_cnt  = cnt_q;
    if (append) begin
      cur_cnt = CNT_W'(1);
    end else if (match && !sat) begin
      cur_cnt = cnt_q + CNT_W'(1);
    end
    probe_d     = probe_i;
    probe_d.hit = probe_i.hit | match;
    probe_d.app = probe_i.app | append;
    probe_d.inc = probe_i.inc | append | (match && !sat);
    bcnt_d      = bcnt_i;
    bhash_d     = bhash_i;
    // ties go to the later slot
    if ((occupied || append) && (cur_cnt >= bcnt_i)) begin
      bcnt_d  = cur_cnt;
      bhash_d = append ? key_i : hash_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (append) begin
      hash_q <= key_i;
    end
    if (append || match) begin
      cnt_q <= cur_cnt;
    end
    key_q   <= key_i;
    bcnt_q  <= bcnt_d;
    bhash_q <= bhash_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;
  assign key_o   = key_q;
  assign bcnt_o  = bcnt_q;
  assign bhash_o = bhash_q;

endmodule

// File: src/hfmt_div.sv
// hfmt_div: best share in Q7.8, count * 25600 / total, one quotient bit a cycle.
// Depends on hfmt_pkg.
module hfmt_div import hfmt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] cnt_i,
  input  logic [CNT_W-1:0] total_i,
  output logic             done_o,
  output logic [PCT_W-1:0] pct_o
);

  localparam int unsigned PW = CNT_W + PCT_W;
  localparam int unsigned CW = $clog2(PCT_W + 1);

  logic          run_q, load_q, done_q;
  logic [CW-1:0] step_q;
  logic [PW-1:0] prod_q;
  logic [CNT_W-1:0] den_q, rem_q;
  logic [PCT_W-1:0] lo_q, quo_q;
  logic [CNT_W:0]   rem_sh, diff;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, lo_q[PCT_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      load_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        load_q <= 1'b1;
        step_q <= CW'(PCT_W);
      end else if (run_q) begin
        if (load_q) begin
          load_q <= 1'b0;
        end else begin
          step_q <= step_q - CW'(1);
          if (step_q == CW'(1)) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PW'(cnt_i) * PW'(PCT_SCALE);
      den_q  <= total_i;
    end else if (run_q && load_q) begin
      // quotient fits PCT_W bits, so the top part is already below den
      rem_q <= prod_q[PW-1:PCT_W];
      lo_q  <= prod_q[PCT_W-1:0];
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      lo_q  <= lo_q << 1;
      quo_q <= {quo_q[PCT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign pct_o  = (den_q == '0) ? '0 : quo_q;

endmodule

// File: src/hash_frequency_mode_tracker_top.sv
// An add's result beat follows its input beat once the probe has walked the cell chain
//   and the divider has finished; a clear's result beat comes in the cycle after it.
// Throughput: one item at a time, next beat accepted in the cycle after the strobe.
// The add path is the probe walking the cell chain one slot a cycle, then the serial
//   divider (multiply, load, 15 quotient bits) and the result register. Reset (rst_ni
//   low, async) empties the table and returns to idle; slot contents stay undefined,
//   only the fill count guards them. The receiver cannot stall.
module hash_frequency_mode_tracker_top import hfmt_pkg::*; #(
  parameter int unsigned ENTRIES   = ENTRIES_DEF,
  parameter int unsigned HASH_BITS = HASH_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             cmd_i,
  input  logic [31:0]      hash_value_i,
  output logic             result_valid_o,
  output logic [OUT_W-1:0] best_hash_o,
  output logic [CNT_W-1:0] best_count_o,
  output logic [PCT_W-1:0] best_percent_o,
  output logic             dropped_o
);

  localparam int unsigned UW = $clog2(ENTRIES + 1);

  state_e state_q, state_d;
  logic   accept, go_scan, go_clear;

  // fill count and running total of counted adds
  logic [UW-1:0]    used_q;
  logic [CNT_W-1:0] total_q, total_d;

  // probe chain: index k is the input of cell k, ENTRIES is the tail
  probe_t               probe  [ENTRIES+1];
  logic [HASH_BITS-1:0] key    [ENTRIES+1];
  logic [CNT_W-1:0]     bcnt   [ENTRIES+1];
  logic [HASH_BITS-1:0] bhash  [ENTRIES+1];

  probe_t               tail;
  logic                 div_done;
  logic [PCT_W-1:0]     div_pct;

  logic [OUT_W-1:0] best_hash_q;
  logic [CNT_W-1:0] best_count_q;
  logic [PCT_W-1:0] pct_q;
  logic             dropped_q;

  assign accept   = start && !busy;
  assign go_scan  = accept && (cmd_i == CMD_ADD);
  assign go_clear = accept && (cmd_i == CMD_CLEAR);

  // head of the chain: a fresh probe beat with an empty running best
  always_comb begin
    probe[0]     = '0;
    probe[0].vld = go_scan;
    key[0]       = HASH_BITS'(hash_value_i);
    bcnt[0]      = '0;
    bhash[0]     = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    hfmt_cell #(
      .HASH_BITS (HASH_BITS),
      .UW        (UW),
      .IDX       (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .used_i  (used_q),
      .probe_i (probe[g]),
      .key_i   (key[g]),
      .bcnt_i  (bcnt[g]),
      .bhash_i (bhash[g]),
      .probe_o (probe[g+1]),
      .key_o   (key[g+1]),
      .bcnt_o  (bcnt[g+1]),
      .bhash_o (bhash[g+1])
    );
  end

  assign tail = probe[ENTRIES];

  // saturating total, as seen after this beat
  always_comb begin
    total_d = total_q;
    if (tail.vld && tail.inc && (total_q != CNT_MAX)) begin
      total_d = total_q + CNT_W'(1);
    end
  end

  hfmt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tail.vld),
    .cnt_i   (bcnt[ENTRIES]),
    .total_i (total_d),
    .done_o  (div_done),
    .pct_o   (div_pct)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (go_scan) begin
          state_d = S_SCAN;
        end else if (go_clear) begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        if (tail.vld) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy           = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      S_IDLE:  busy = 1'b0;
      S_DONE:  result_valid_o = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      if (go_clear) begin
        used_q  <= '0;
        total_q <= '0;
      end else if (tail.vld) begin
        used_q  <= used_q + UW'(tail.app);
        total_q <= total_d;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (go_clear) begin
      best_hash_q  <= '0;
      best_count_q <= '0;
      pct_q        <= '0;
      dropped_q    <= 1'b0;
    end else begin
      if (tail.vld) begin
        best_hash_q  <= OUT_W'(bhash[ENTRIES]);
        best_count_q <= bcnt[ENTRIES];
        // new hash and no free slot left
        dropped_q    <= !tail.hit && !tail.app;
      end
      if (div_done) begin
        pct_q <= div_pct;
      end
    end
  end

  assign best_hash_o    = best_hash_q;
  assign best_count_o   = best_count_q;
  assign best_percent_o = pct_q;
  assign dropped_o      = dropped_q;

endmodule

// File: src/hfmt_checker.sv
// hfmt_checker: port-level properties of the mode tracker, bound to the top level.
// Depends on hash_frequency_mode_tracker_top ports and hfmt_pkg.
module hfmt_checker import hfmt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_valid_o,
  input logic [OUT_W-1:0] best_hash_o,
  input logic [CNT_W-1:0] best_count_o,
  input logic [PCT_W-1:0] best_percent_o
);

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (best_percent_o <= PCT_SCALE))
    else $error("share above 100 percent");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (best_count_o == '0)) |-> ((best_hash_o == '0) &&
      (best_percent_o == '0)))
    else $error("empty result not all zero");

endmodule

bind hash_frequency_mode_tracker_top hfmt_checker u_hfmt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .best_hash_o    (best_hash_o),
  .best_count_o   (best_count_o),
  .best_percent_o (best_percent_o)
);

// File: test/hash_frequency_mode_tracker_top_test.sv
// Self-checking bench for hash_frequency_mode_tracker_top: directed table plus random
// tally runs, every result checked against an in-bench model or a result typed in the plan.
// Depends on hfmt_pkg and the top level; nothing else.
module hash_frequency_mode_tracker_top_test;
  import hfmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PLAN_ROWS    = 16;
  localparam int unsigned RANDOM_BEATS = 1870;
  // drain for longer than the longest add
  localparam int unsigned DRAIN_CYCLES = ENTRIES_DEF + 40;

  // one result beat: the mode of the table as the block reports it
  typedef struct packed {
    logic [OUT_W-1:0] hash;
    logic [CNT_W-1:0] count;
    logic [PCT_W-1:0] pct;
    logic             drop;
  } mode_result_t;

  // one row of the directed plan; reps > 1 sends hash, hash+1, ... in a row
  typedef struct packed {
    logic         cmd;
    logic [31:0]  hash;
    logic [7:0]   reps;
    logic         typed;  // use res below instead of the model
    mode_result_t res;
  } tally_row_t;

  localparam tally_row_t TALLY_PLAN [PLAN_ROWS] = '{
    // first add straight out of reset: sole entry owns 100%
    '{CMD_ADD,   32'h0000_0000, 8'd1,  1'b1, '{32'h0000_0000, 32'd1, 15'd25600, 1'b0}},
    // tie at count 1: the later slot wins, half the adds
    '{CMD_ADD,   32'hFFFF_FFFF, 8'd1,  1'b1, '{32'hFFFF_FFFF, 32'd1, 15'd12800, 1'b0}},
    '{CMD_ADD,   32'h0000_0000, 8'd1,  1'b0, '0},
    '{CMD_ADD,   32'hFFFF_FFFF, 8'd1,  1'b0, '0},
    '{CMD_ADD,   32'h0000_0000, 8'd1,  1'b0, '0},
    '{CMD_ADD,   32'h5555_5555, 8'd1,  1'b0, '0},
    '{CMD_ADD,   32'hAAAA_AAAA, 8'd1,  1'b0, '0},
    // clear ignores the hash and reports all zeros; twice to hit clear-on-empty
    '{CMD_CLEAR, 32'hFFFF_FFFF, 8'd1,  1'b1, '0},
    '{CMD_CLEAR, 32'h0000_0000, 8'd1,  1'b1, '0},
    // fill every slot with a distinct hash
    '{CMD_ADD,   32'h1000_0000, 8'd64, 1'b0, '0},
    // full table, new hash: dropped, mode is the last slot at 1/64
    '{CMD_ADD,   32'h7FFF_FFFF, 8'd1,  1'b1, '{32'h1000_003F, 32'd1, 15'd400, 1'b1}},
    // known hash still counts on a full table
    '{CMD_ADD,   32'h1000_0000, 8'd1,  1'b0, '0},
    '{CMD_ADD,   32'h0000_0001, 8'd1,  1'b0, '0},
    '{CMD_ADD,   32'h1000_003F, 8'd1,  1'b0, '0},
    '{CMD_CLEAR, 32'h1234_5678, 8'd1,  1'b1, '0},
    '{CMD_ADD,   32'h0000_0001, 8'd1,  1'b1, '{32'h0000_0001, 32'd1, 15'd25600, 1'b0}}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             cmd_i;
  logic [31:0]      hash_value_i;
  logic             result_valid_o;
  logic [OUT_W-1:0] best_hash_o;
  logic [CNT_W-1:0] best_count_o;
  logic [PCT_W-1:0] best_percent_o;
  logic             dropped_o;

  hash_frequency_mode_tracker_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .hash_value_i   (hash_value_i),
    .result_valid_o (result_valid_o),
    .best_hash_o    (best_hash_o),
    .best_count_o   (best_count_o),
    .best_percent_o (best_percent_o),
    .dropped_o      (dropped_o)
  );

  // model of the tally table
  logic [31:0]      slot_hash [ENTRIES_DEF];
  logic [CNT_W-1:0] slot_cnt  [ENTRIES_DEF];
  int unsigned      slots_used;
  logic [CNT_W-1:0] adds_total;
  int unsigned      mode_slot;
  logic [CNT_W-1:0] mode_cnt;

  mode_result_t pending_modes [$];
  int unsigned  fail_count;
  int unsigned  calm_left;  // beats left in a no-idle stretch

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Apply one command to the model and return the mode it reports.
  function automatic mode_result_t tally_mode(input logic cmd, input logic [31:0] hash);
    mode_result_t res;
    logic         hit;
    logic [63:0]  scaled;
    int unsigned  k;
    res = '0;
    hit = 1'b0;
    if (cmd == CMD_CLEAR) begin
      slots_used = 0;
      adds_total = '0;
      mode_slot  = 0;
      mode_cnt   = '0;
    end else begin
      for (k = 0; k < slots_used; k++) begin
        if (!hit && slot_hash[k] == hash) begin
          hit = 1'b1;
          // a saturated count freezes, and so does the total for that add
          if (slot_cnt[k] != CNT_MAX) begin
            slot_cnt[k]++;
            if (adds_total != CNT_MAX) adds_total++;
          end
        end
      end
      if (!hit) begin
        if (slots_used < ENTRIES_DEF) begin
          slot_hash[slots_used] = hash;
          slot_cnt[slots_used]  = 1;
          slots_used++;
          if (adds_total != CNT_MAX) adds_total++;
        end else begin
          res.drop = 1'b1;
        end
      end
      // >= hands ties to the most recently filled slot
      mode_slot = 0;
      mode_cnt  = '0;
      for (k = 0; k < slots_used; k++) begin
        if (slot_cnt[k] >= mode_cnt) begin
          mode_cnt  = slot_cnt[k];
          mode_slot = k;
        end
      end
    end
    if (slots_used != 0) begin
      res.hash  = slot_hash[mode_slot];
      res.count = mode_cnt;
      if (adds_total != '0) begin
        scaled  = (64'(mode_cnt) * 64'(PCT_SCALE)) / 64'(adds_total);
        res.pct = (scaled > 64'(PCT_SCALE)) ? PCT_SCALE : PCT_W'(scaled);
      end
    end
    return res;
  endfunction

  // Offer one command beat after a random idle gap; on accept, queue its expected mode.
  task automatic issue_beat(input logic cmd, input logic [31:0] hash, input logic typed,
                            input mode_result_t typed_res);
    int unsigned  gap;
    mode_result_t want;
    if (calm_left != 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(4, 24);
    end
    if (gap != 0) begin
      start <= 1'b0;
      // half the gaps start once the block has gone idle, the rest overlap its work
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (busy);
      end
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    cmd_i        <= cmd;
    hash_value_i <= hash;
    // busy read here is its value just before the edge
    do @(posedge clk_i); while (busy);
    want = tally_mode(cmd, hash);
    pending_modes.push_back(typed ? typed_res : want);
  endtask

  // Result side: strobe lasts one cycle and cannot be held off.
  always @(posedge clk_i) begin : mode_check
    mode_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_modes.size() == 0) begin
        $error("result beat with nothing expected: hash %h count %0d", best_hash_o,
               best_count_o);
        fail_count++;
      end else begin
        want = pending_modes.pop_front();
        if (best_hash_o !== want.hash) begin
          $error("best_hash: expected %h, got %h", want.hash, best_hash_o);
          fail_count++;
        end
        if (best_count_o !== want.count) begin
          $error("best_count: expected %0d, got %0d", want.count, best_count_o);
          fail_count++;
        end
        if (best_percent_o !== want.pct) begin
          $error("best_percent: expected %0d, got %0d", want.pct, best_percent_o);
          fail_count++;
        end
        if (dropped_o !== want.drop) begin
          $error("dropped: expected %b, got %b", want.drop, dropped_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned row_i;
    int unsigned rep_i;
    int unsigned beat_i;
    int unsigned kind;
    int unsigned pool_n;
    int unsigned run_len;
    int unsigned pick;
    int unsigned random_beats;
    logic        cmd;
    logic [31:0] hash;
    logic [31:0] hash_pool [128];

    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = CMD_ADD;
    hash_value_i = '0;
    fail_count   = 0;
    calm_left    = 0;
    slots_used   = 0;
    adds_total   = '0;
    mode_slot    = 0;
    mode_cnt     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed plan
    for (row_i = 0; row_i < PLAN_ROWS; row_i++) begin
      for (rep_i = 0; rep_i < TALLY_PLAN[row_i].reps; rep_i++) begin
        issue_beat(TALLY_PLAN[row_i].cmd, TALLY_PLAN[row_i].hash + rep_i,
                   TALLY_PLAN[row_i].typed, TALLY_PLAN[row_i].res);
      end
    end

    // Random runs, mostly opened by a clear:
    //   small pools   -> high counts, frequent ties and mode changes
    //   large pools   -> table fills, then new hashes get dropped
    //   noise         -> random hashes, a quarter of them in 0..15, with stray clears
    // Count saturation needs 2^32 - 1 adds and is out of reach here.
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 9) != 0) begin
        issue_beat(CMD_CLEAR, $urandom, 1'b0, '0);
        random_beats++;
      end
      if (kind == 9) begin
        run_len = $urandom_range(10, 80);
        for (beat_i = 0; beat_i < run_len; beat_i++) begin
          cmd  = ($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_ADD;
          hash = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
          issue_beat(cmd, hash, 1'b0, '0);
          random_beats++;
        end
      end else begin
        pool_n  = (kind < 6) ? $urandom_range(1, 40) : $urandom_range(60, 100);
        run_len = (kind < 6) ? $urandom_range(5, 60) : $urandom_range(70, 140);
        for (pick = 0; pick < pool_n; pick++) begin
          case ($urandom_range(0, 7))
            0:       hash_pool[pick] = '0;
            1:       hash_pool[pick] = '1;
            2:       hash_pool[pick] = 32'd1 << $urandom_range(0, 31);
            default: hash_pool[pick] = $urandom;
          endcase
        end
        for (beat_i = 0; beat_i < run_len; beat_i++) begin
          pick = $urandom_range(0, pool_n - 1);
          // skew toward the front of the pool so a clear leader forms
          if ($urandom_range(0, 3) == 0) pick = pick % ((pool_n + 3) / 4);
          issue_beat(CMD_ADD, hash_pool[pick], 1'b0, '0);
          random_beats++;
        end
      end
    end
    start <= 1'b0;

    while (pending_modes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run guard: fails the run if it hangs.
  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

endmodule
